@@ hdl/szc_pkg.sv @@
`default_nettype none

package szc_pkg;

   // Configuration register layout.
   localparam int CSR_BITS       = 11;
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLICE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLICE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRANSPOSE_XY = 2'd2;

   // Register reset values and the smallest usable slice dimension.
   localparam logic [CSR_BITS-1:0] RESET_SLICE_WIDTH  = 11'd64;
   localparam logic [CSR_BITS-1:0] RESET_SLICE_HEIGHT = 11'd64;
   localparam int MIN_DIM = 2;

   // Row counter width follows the height register.
   localparam int ROW_BITS = CSR_BITS;

   // Output coordinate width.
   localparam int COORD_BITS = 18;

   // Request queue between the front and the back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int LEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);

   // Back end sequencer states.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_EMIT
   } back_state_type;

endpackage

`default_nettype wire

@@ hdl/szc_queue.sv @@
`default_nettype none

module szc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire logic [WIDTH-1:0]             push_data,
   input  wire logic                         pop,
   output logic      [WIDTH-1:0]             pop_data,
   output logic                              empty,
   output logic      [$clog2(DEPTH+1)-1:0]   level
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slots_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_BITS-1:0] level_ff, level_in;
   logic                do_pop;

   assign empty    = (level_ff == '0);
   assign level    = level_ff;
   assign pop_data = slots_ff[rd_ptr_ff];
   assign do_pop   = pop && !empty;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (!push && do_pop) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Storage slots; the front only pushes when there is room.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ hdl/szc_front.sv @@
`default_nettype none

module szc_front #(
   parameter int MAX_WIDTH   = 1024,
   parameter int SAMPLE_BITS = 16,
   parameter int JOB_BITS    = 2 + 3 * 16 + 10 + 11
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   output logic                                     full,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_sample,
   input  wire logic                                req_first_of_slice,
   input  wire logic [szc_pkg::CSR_BITS-1:0]        cfg_width,
   input  wire logic [szc_pkg::CSR_BITS-1:0]        cfg_height,
   input  wire logic [szc_pkg::LEVEL_BITS-1:0]      queue_level,
   output logic                                     job_push,
   output logic [JOB_BITS-1:0]                      job_data
);

   localparam int COL_BITS = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_BITS = szc_pkg::ROW_BITS;
   localparam int CMP_BITS = (COL_BITS + 1 > szc_pkg::CSR_BITS) ? COL_BITS + 1
                                                                : szc_pkg::CSR_BITS;

   function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] a);
      return a[SAMPLE_BITS-1] ? (~a + 1'b1) : a;
   endfunction

   function automatic logic opposite(input logic [SAMPLE_BITS-1:0] a,
                                     input logic [SAMPLE_BITS-1:0] b);
      logic a_pos, a_neg, b_pos, b_neg;
      a_neg = a[SAMPLE_BITS-1];
      b_neg = b[SAMPLE_BITS-1];
      a_pos = !a_neg && (a != '0);
      b_pos = !b_neg && (b != '0);
      return (a_neg && b_pos) || (a_pos && b_neg);
   endfunction

   logic                          accept;
   logic [CMP_BITS-1:0]           width_raw, width_eff;
   logic [ROW_BITS-1:0]           height_eff;
   logic [COL_BITS-1:0]           col_start, cur_col;
   logic [ROW_BITS-1:0]           row_start, cur_row;
   logic [ROW_BITS:0]             row_adv, row_next;
   logic [CMP_BITS-1:0]           col_next;
   logic                          wrap_start;

   logic [COL_BITS-1:0]           col_ff, col_in;
   logic [ROW_BITS-1:0]           row_ff, row_in;
   logic [SAMPLE_BITS-1:0]        left_ff;

   logic [SAMPLE_BITS-1:0]        row_store [MAX_WIDTH];
   logic [SAMPLE_BITS-1:0]        upper_ff;

   logic                          s1_valid_ff;
   logic [SAMPLE_BITS-1:0]        s1_cur_ff, s1_left_ff;
   logic [COL_BITS-1:0]           s1_col_ff;
   logic [ROW_BITS-1:0]           s1_row_ff;
   logic                          cross_h, cross_v;
   logic [szc_pkg::LEVEL_BITS:0]  pending;

   // Room is reserved in the queue for the request held in the classify stage.
   assign pending = {1'b0, queue_level} + (szc_pkg::LEVEL_BITS + 1)'(s1_valid_ff);
   assign full    = pending >= (szc_pkg::LEVEL_BITS + 1)'(szc_pkg::QUEUE_DEPTH);
   assign accept  = push && !full;

   // Clamp the slice dimensions to the usable range.
   always_comb begin
      width_raw = CMP_BITS'(cfg_width);
      if (width_raw < CMP_BITS'(szc_pkg::MIN_DIM)) begin
         width_eff = CMP_BITS'(szc_pkg::MIN_DIM);
      end else if (width_raw > CMP_BITS'(MAX_WIDTH)) begin
         width_eff = CMP_BITS'(MAX_WIDTH);
      end else begin
         width_eff = width_raw;
      end
      if (cfg_height < ROW_BITS'(szc_pkg::MIN_DIM)) begin
         height_eff = ROW_BITS'(szc_pkg::MIN_DIM);
      end else begin
         height_eff = cfg_height;
      end
   end

   // Raster position of the incoming request and of the one after it.
   always_comb begin
      col_start  = req_first_of_slice ? '0 : col_ff;
      row_start  = req_first_of_slice ? '0 : row_ff;
      wrap_start = CMP_BITS'(col_start) >= width_eff;
      row_adv    = wrap_start ? {1'b0, row_start} + 1'b1 : {1'b0, row_start};
      cur_row    = (row_adv >= {1'b0, height_eff}) ? '0 : row_adv[ROW_BITS-1:0];
      cur_col    = wrap_start ? '0 : col_start;
      col_next   = CMP_BITS'(cur_col) + 1'b1;
      row_next   = {1'b0, cur_row} + 1'b1;
      if (col_next >= width_eff) begin
         col_in = '0;
         row_in = (row_next >= {1'b0, height_eff}) ? '0 : row_next[ROW_BITS-1:0];
      end else begin
         col_in = col_next[COL_BITS-1:0];
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            left_ff <= req_sample;
         end
      end
   end

   // Line store: read the sample above before it is overwritten.
   always_ff @(posedge clock) begin
      if (accept) begin
         upper_ff            <= row_store[cur_col];
         row_store[cur_col]  <= req_sample;
      end
   end

   // Classify stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff  <= req_sample;
         s1_left_ff <= left_ff;
         s1_col_ff  <= cur_col;
         s1_row_ff  <= cur_row;
      end
   end

   // Sign change tests against the left and upper neighbors.
   assign cross_h  = (s1_col_ff != '0) && opposite(s1_left_ff, s1_cur_ff);
   assign cross_v  = (s1_row_ff != '0) && opposite(upper_ff, s1_cur_ff);
   assign job_push = s1_valid_ff && (cross_h || cross_v);
   assign job_data = {cross_h, cross_v, magnitude(s1_left_ff), magnitude(upper_ff),
                      magnitude(s1_cur_ff), s1_col_ff, s1_row_ff};

endmodule

`default_nettype wire

@@ hdl/szc_back.sv @@
`default_nettype none

module szc_back #(
   parameter int MAX_WIDTH   = 1024,
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 8,
   parameter int JOB_BITS    = 2 + 3 * 16 + 10 + 11
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               job_valid,
   input  wire logic [JOB_BITS-1:0]                job_data,
   output logic                                    job_pop,
   input  wire logic                               cfg_transpose,
   output logic                                    empty,
   input  wire logic                               pop,
   output logic [szc_pkg::COORD_BITS-1:0]          rsp_point_x,
   output logic [szc_pkg::COORD_BITS-1:0]          rsp_point_y,
   output logic                                    rsp_last_of_run
);

   localparam int COL_BITS  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_BITS  = szc_pkg::ROW_BITS;
   localparam int DEN_BITS  = SAMPLE_BITS + 1;
   localparam int STEP_BITS = $clog2(FRAC_BITS);
   localparam int WIDE_BITS = szc_pkg::COORD_BITS + COL_BITS + ROW_BITS + FRAC_BITS;
   localparam int CB        = szc_pkg::COORD_BITS;

   // Unpacked view of the queue head.
   logic                   hd_h, hd_v;
   logic [SAMPLE_BITS-1:0] hd_left, hd_up, hd_cur;
   logic [COL_BITS-1:0]    hd_col;
   logic [ROW_BITS-1:0]    hd_row;

   assign {hd_h, hd_v, hd_left, hd_up, hd_cur, hd_col, hd_row} = job_data;

   szc_pkg::back_state_type state_ff, state_in;

   logic                   v_pending_ff, v_pending_in;
   logic                   phase_v_ff, phase_v_in;
   logic                   take_job, load_div, emit;
   logic [SAMPLE_BITS-1:0] up_ff, cur_ff;
   logic [COL_BITS-1:0]    col_ff;
   logic [ROW_BITS-1:0]    row_ff;
   logic [DEN_BITS-1:0]    rem_ff, rem_in, den_ff, den_in;
   logic [FRAC_BITS-1:0]   quo_ff;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [DEN_BITS:0]      rem_shift;
   logic                   rem_ge;
   logic [SAMPLE_BITS-1:0] ld_num, ld_cur;

   logic                   out_valid_ff, out_valid_in;
   logic [CB-1:0]          out_x_ff, out_y_ff;
   logic                   out_last_ff;
   logic [WIDE_BITS-1:0]   x_int, y_int, x_wide, y_wide;
   logic [CB-1:0]          pt_x, pt_y;

   assign empty           = !out_valid_ff;
   assign rsp_point_x     = out_x_ff;
   assign rsp_point_y     = out_y_ff;
   assign rsp_last_of_run = out_last_ff;

   // One restoring division step: quotient bit from the doubled remainder.
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = rem_shift >= {1'b0, den_ff};

   // Sequencer: load a division, iterate it, then hand the point to the output.
   always_comb begin
      state_in     = state_ff;
      v_pending_in = v_pending_ff;
      phase_v_in   = phase_v_ff;
      step_in      = step_ff;
      take_job     = 1'b0;
      load_div     = 1'b0;
      emit         = 1'b0;
      ld_num       = phase_v_ff ? up_ff : '0;
      ld_cur       = cur_ff;
      unique case (state_ff)
         szc_pkg::BK_IDLE: begin
            ld_num = hd_h ? hd_left : hd_up;
            ld_cur = hd_cur;
            if (job_valid) begin
               take_job     = 1'b1;
               load_div     = 1'b1;
               v_pending_in = hd_v;
               phase_v_in   = !hd_h;
               step_in      = '0;
               state_in     = szc_pkg::BK_DIVIDE;
            end
         end
         szc_pkg::BK_DIVIDE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(FRAC_BITS - 1)) begin
               state_in = szc_pkg::BK_EMIT;
            end
         end
         szc_pkg::BK_EMIT: begin
            ld_num = up_ff;
            if (!out_valid_ff || pop) begin
               emit = 1'b1;
               if (!phase_v_ff && v_pending_ff) begin
                  load_div   = 1'b1;
                  phase_v_in = 1'b1;
                  step_in    = '0;
                  state_in   = szc_pkg::BK_DIVIDE;
               end else begin
                  state_in = szc_pkg::BK_IDLE;
               end
            end
         end
         default: begin
            state_in = szc_pkg::BK_IDLE;
         end
      endcase
   end

   assign job_pop = take_job;

   // Divider operands: the numerator is always below the denominator.
   always_comb begin
      if (load_div) begin
         rem_in = DEN_BITS'(ld_num);
         den_in = DEN_BITS'(ld_num) + DEN_BITS'(ld_cur);
      end else begin
         rem_in = rem_ge ? DEN_BITS'(rem_shift - {1'b0, den_ff}) : rem_shift[DEN_BITS-1:0];
         den_in = den_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= szc_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_pending_ff <= v_pending_in;
      phase_v_ff   <= phase_v_in;
      step_ff      <= step_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      if (state_ff == szc_pkg::BK_DIVIDE) begin
         quo_ff <= {quo_ff[FRAC_BITS-2:0], rem_ge};
      end
      if (take_job) begin
         up_ff  <= hd_up;
         cur_ff <= hd_cur;
         col_ff <= hd_col;
         row_ff <= hd_row;
      end
   end

   // Point coordinates: the neighbor's index plus the fraction on the crossing axis.
   always_comb begin
      if (phase_v_ff) begin
         x_int  = WIDE_BITS'(col_ff);
         y_int  = WIDE_BITS'(row_ff) - 1'b1;
         x_wide = x_int << FRAC_BITS;
         y_wide = (y_int << FRAC_BITS) + WIDE_BITS'(quo_ff);
      end else begin
         x_int  = WIDE_BITS'(col_ff) - 1'b1;
         y_int  = WIDE_BITS'(row_ff);
         x_wide = (x_int << FRAC_BITS) + WIDE_BITS'(quo_ff);
         y_wide = y_int << FRAC_BITS;
      end
      pt_x = cfg_transpose ? y_wide[CB-1:0] : x_wide[CB-1:0];
      pt_y = cfg_transpose ? x_wide[CB-1:0] : y_wide[CB-1:0];
   end

   // Output register: one finished point waits here while the next divides.
   assign out_valid_in = emit || (out_valid_ff && !pop);

   always_ff @(posedge clock) begin
      if (emit) begin
         out_x_ff    <= pt_x;
         out_y_ff    <= pt_y;
         out_last_ff <= phase_v_ff || !v_pending_ff;
      end
   end

endmodule

`default_nettype wire

@@ hdl/slice_zero_crossing_points.sv @@
// Path: a request with a sign change passes the classify stage, the queue, the divider
// and the output register to the result ports; its second point takes a second division.
// Throughput: one request per cycle while no contour points arise and the queue has room; the
// shared divider works on one point at a time, a request's first point and then its second.
// Reset clears the counters, the left sample, the queue and the registers (width 64,
// height 64, no transpose); the line store is not cleared and needs no clearing pass.
`default_nettype none

module slice_zero_crossing_points #(
   parameter int MAX_WIDTH   = 1024,
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push,
   output logic                                       full,
   input  wire logic signed [SAMPLE_BITS-1:0]         req_sample,
   input  wire logic                                  req_first_of_slice,
   output logic                                       empty,
   input  wire logic                                  pop,
   output logic [szc_pkg::COORD_BITS-1:0]             rsp_point_x,
   output logic [szc_pkg::COORD_BITS-1:0]             rsp_point_y,
   output logic                                       rsp_last_of_run,
   input  wire logic                                  csr_write_enable,
   input  wire logic [szc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [szc_pkg::CSR_BITS-1:0]          csr_write_data
);

   localparam int COL_BITS = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int JOB_BITS = 2 + 3 * SAMPLE_BITS + COL_BITS + szc_pkg::ROW_BITS;

   logic [szc_pkg::CSR_BITS-1:0]   width_ff, height_ff;
   logic                           transpose_ff;
   logic                           job_push, job_pop, queue_empty;
   logic [JOB_BITS-1:0]            job_in, job_out;
   logic [szc_pkg::LEVEL_BITS-1:0] queue_level;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= szc_pkg::RESET_SLICE_WIDTH;
         height_ff    <= szc_pkg::RESET_SLICE_HEIGHT;
         transpose_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            szc_pkg::CSR_SLICE_WIDTH:  width_ff     <= csr_write_data;
            szc_pkg::CSR_SLICE_HEIGHT: height_ff    <= csr_write_data;
            szc_pkg::CSR_TRANSPOSE_XY: transpose_ff <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // Front: raster tracking, line store and sign change detection.
   szc_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .JOB_BITS    (JOB_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_sample         (req_sample),
      .req_first_of_slice (req_first_of_slice),
      .cfg_width          (width_ff),
      .cfg_height         (height_ff),
      .queue_level        (queue_level),
      .job_push           (job_push),
      .job_data           (job_in)
   );

   // Requests that produce points wait here for the divider.
   szc_queue #(
      .WIDTH (JOB_BITS),
      .DEPTH (szc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .pop_data  (job_out),
      .empty     (queue_empty),
      .level     (queue_level)
   );

   // Back: fraction division and point output.
   szc_back #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .JOB_BITS    (JOB_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (!queue_empty),
      .job_data        (job_out),
      .job_pop         (job_pop),
      .cfg_transpose   (transpose_ff),
      .empty           (empty),
      .pop             (pop),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire
